FILE: sv/bitmap_slot_allocator_macros.svh
// Assertion helpers shared by the allocator RTL.
`ifndef BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSA_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bsa_pkg.sv
package bsa_pkg;

  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_FREE = 2'd2;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ACNT = 8'b0000_0010,
    S_ACHK = 8'b0000_0100,
    S_SCAN = 8'b0000_1000,
    S_FIND = 8'b0001_0000,
    S_OPEN = 8'b0010_0000,
    S_FCHK = 8'b0100_0000,
    S_RES  = 8'b1000_0000
  } state_t;

endpackage

FILE: sv/bitmap_slot_allocator.sv
// Bitmap slot allocator. Each input word is one action (allocate, free, clear all) and gives
// exactly one result word. Items are handled one at a time; the free bitmaps live in a
// single-port-read, single-port-write RAM of MAX_BUFFERS * ceil(SLOTS_MAX/WORD_BITS) words and
// the per-buffer counts in a small RAM; a search reads one bitmap word per cycle. With
// W = ceil(SLOTS_MAX/WORD_BITS): allocate where the slot at the buffer's count is free passes
// through S_ACNT, S_ACHK and S_RES; allocate that falls back to a search adds S_SCAN over up to
// W words and S_FIND; allocate that opens a buffer writes its W bitmap words in S_OPEN (one word
// written per cycle), then S_RES; free passes through S_FCHK and S_RES; a free rejected on its
// buffer or slot index, allocate with every buffer open and full, clear all and the unused action
// go straight to S_RES. A finished result waits in the output register while the next input word
// is taken; a result that finds that register still occupied holds the block until out_ready. The
// slots_per_buffer register is accepted at once but must only be written while no word is in flight.
`include "bitmap_slot_allocator_macros.svh"

module bitmap_slot_allocator #(
  parameter int MAX_BUFFERS = 8,
  parameter int SLOTS_MAX   = 512,
  parameter int WORD_BITS   = 64,
  localparam int BUF_W  = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1,
  localparam int SLOT_W = $clog2(SLOTS_MAX),
  localparam int CNT_W  = $clog2(SLOTS_MAX + 1),
  localparam int TOT_W  = $clog2(MAX_BUFFERS * SLOTS_MAX + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bsa_pkg::ACT_W-1:0]  in_action,
  input  logic [BUF_W-1:0]           in_free_buffer,
  input  logic [SLOT_W-1:0]          in_free_slot,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bsa_pkg::STAT_W-1:0] out_status,
  output logic [BUF_W-1:0]           out_got_buffer,
  output logic [SLOT_W-1:0]          out_got_slot,
  output logic [TOT_W-1:0]           out_in_use,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CNT_W-1:0]           cfg_slots_per_buffer
);

  localparam int WPB      = (SLOTS_MAX + WORD_BITS - 1) / WORD_BITS;
  localparam int OPEN_W   = $clog2(MAX_BUFFERS + 1);
  localparam int CMP_W    = OPEN_W + BUF_W;
  localparam int WIDX_W   = (WPB > 1) ? $clog2(WPB) : 1;
  localparam int SCW_W    = $clog2(WPB + 1);
  localparam int WB_W     = $clog2(WORD_BITS);
  localparam int BM_DEPTH = MAX_BUFFERS * WPB;
  localparam int BM_AW    = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
  // word index = (x * RECIP) >> SH, exact for every x below 2**CNT_W
  localparam int SH       = CNT_W + WB_W + 1;
  localparam int RECIP    = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W   = CNT_W + SH;

  function automatic logic [WIDX_W-1:0] word_of(input logic [CNT_W-1:0] x);
    logic [PROD_W-1:0] p;
    p = PROD_W'(x) * PROD_W'(RECIP);
    return p[SH +: WIDX_W];
  endfunction

  function automatic logic [BM_AW-1:0] word_addr(input logic [BUF_W-1:0] b,
                                                 input logic [WIDX_W-1:0] w);
    return BM_AW'(b) * BM_AW'(WPB) + BM_AW'(w);
  endfunction

  bsa_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]       slots_r, slots_nxt;
  logic [MAX_BUFFERS-1:0] has_space_r, has_space_nxt;
  logic [OPEN_W-1:0]      open_r, open_nxt;
  logic [TOT_W-1:0]       total_r, total_nxt;
  logic [SCW_W-1:0]       scan_w_r, scan_w_nxt;
  logic                   scan_vld_r, scan_vld_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [BUF_W-1:0]     pick_r, pick_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [WIDX_W-1:0]    wsel_r, wsel_nxt;
  logic [WIDX_W-1:0]    scan_cw_r, scan_cw_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [bsa_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [BUF_W-1:0]     res_gb_r, res_gb_nxt;
  logic [SLOT_W-1:0]    res_gs_r, res_gs_nxt;
  logic [bsa_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [BUF_W-1:0]     out_got_buffer_r, out_got_buffer_nxt;
  logic [SLOT_W-1:0]    out_got_slot_r, out_got_slot_nxt;
  logic [TOT_W-1:0]     out_in_use_r, out_in_use_nxt;

  // memory ports
  logic                 bm_we;
  logic [BM_AW-1:0]     bm_waddr, bm_raddr;
  logic [WORD_BITS-1:0] bm_wdata, bm_rd;
  logic                 bu_we;
  logic [BUF_W-1:0]     bu_waddr, bu_raddr;
  logic [CNT_W-1:0]     bu_wdata, bu_rd;

  // helpers
  logic [CNT_W-1:0]     n_eff;
  logic [BUF_W-1:0]     low_buf;
  logic                 any_space;
  logic [WB_W-1:0]      bit_idx;
  logic [WB_W-1:0]      low_bit;
  logic [CNT_W-1:0]     open_lo, open_rem;
  logic [WORD_BITS-1:0] init_word;
  logic [CNT_W-1:0]     cnt_inc;
  logic [WIDX_W-1:0]    fs_word;
  logic                 commit_en;
  logic [WORD_BITS-1:0] commit_word;
  logic [WB_W-1:0]      commit_bit;
  logic [SLOT_W-1:0]    commit_slot;

  bsa_ram #(.WIDTH(WORD_BITS), .DEPTH(BM_DEPTH)) u_bitmap_ram (
    .clk     (clk),
    .we      (bm_we),
    .waddr   (bm_waddr),
    .wdata   (bm_wdata),
    .raddr   (bm_raddr),
    .rdata_r (bm_rd)
  );

  bsa_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BUFFERS)) u_count_ram (
    .clk     (clk),
    .we      (bu_we),
    .waddr   (bu_waddr),
    .wdata   (bu_wdata),
    .raddr   (bu_raddr),
    .rdata_r (bu_rd)
  );

  assign in_ready       = (state_r == bsa_pkg::S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_got_buffer = out_got_buffer_r;
  assign out_got_slot   = out_got_slot_r;
  assign out_in_use     = out_in_use_r;

  always_comb begin
    if (slots_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (slots_r > CNT_W'(SLOTS_MAX)) begin
      n_eff = CNT_W'(SLOTS_MAX);
    end else begin
      n_eff = slots_r;
    end
  end

  always_comb begin
    low_buf = '0;
    for (int i = MAX_BUFFERS - 1; i >= 0; i--) begin
      if (has_space_r[i]) begin
        low_buf = BUF_W'(i);
      end
    end
  end
  assign any_space = |has_space_r;

  always_comb begin
    low_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word_r[i]) begin
        low_bit = WB_W'(i);
      end
    end
  end

  // bit position inside the selected word
  assign bit_idx = WB_W'(cnt_r - CNT_W'(wsel_r) * CNT_W'(WORD_BITS));
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign fs_word = word_of(CNT_W'(in_free_slot));

  // fresh buffer: first n_eff bits free, slot 0 handed out straight away
  assign open_lo  = CNT_W'(scan_w_r) * CNT_W'(WORD_BITS);
  assign open_rem = (n_eff > open_lo) ? (n_eff - open_lo) : '0;
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      init_word[i] = (CNT_W'(i) < open_rem);
    end
    if (scan_w_r == '0) begin
      init_word[0] = 1'b0;
    end
  end

  always_comb begin
    state_nxt          = state_r;
    slots_nxt          = cfg_valid ? cfg_slots_per_buffer : slots_r;
    has_space_nxt      = has_space_r;
    open_nxt           = open_r;
    total_nxt          = total_r;
    scan_w_nxt         = scan_w_r;
    scan_vld_nxt       = scan_vld_r;
    out_valid_nxt      = out_valid_r;
    pick_nxt           = pick_r;
    cnt_nxt            = cnt_r;
    wsel_nxt           = wsel_r;
    scan_cw_nxt        = scan_cw_r;
    word_nxt           = word_r;
    res_status_nxt     = res_status_r;
    res_gb_nxt         = res_gb_r;
    res_gs_nxt         = res_gs_r;
    out_status_nxt     = out_status_r;
    out_got_buffer_nxt = out_got_buffer_r;
    out_got_slot_nxt   = out_got_slot_r;
    out_in_use_nxt     = out_in_use_r;

    bm_we     = 1'b0;
    bm_waddr  = word_addr(pick_r, wsel_r);
    bm_wdata  = word_r;
    bm_raddr  = word_addr(pick_r, wsel_r);
    bu_we     = 1'b0;
    bu_waddr  = pick_r;
    bu_wdata  = cnt_inc;
    bu_raddr  = pick_r;

    commit_en   = 1'b0;
    commit_word = word_r;
    commit_bit  = low_bit;
    commit_slot = SLOT_W'(CNT_W'(wsel_r) * CNT_W'(WORD_BITS) + CNT_W'(low_bit));

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      bsa_pkg::S_IDLE: begin
        if (in_valid) begin
          res_status_nxt = bsa_pkg::STAT_OK;
          res_gb_nxt     = '0;
          res_gs_nxt     = '0;
          state_nxt      = bsa_pkg::S_RES;
          unique case (in_action)
            bsa_pkg::ACT_ALLOC: begin
              if (any_space) begin
                pick_nxt  = low_buf;
                bu_raddr  = low_buf;
                state_nxt = bsa_pkg::S_ACNT;
              end else if (open_r < OPEN_W'(MAX_BUFFERS)) begin
                pick_nxt   = BUF_W'(open_r);
                scan_w_nxt = '0;
                state_nxt  = bsa_pkg::S_OPEN;
              end else begin
                res_status_nxt = bsa_pkg::STAT_FULL;
              end
            end
            bsa_pkg::ACT_FREE: begin
              pick_nxt = in_free_buffer;
              cnt_nxt  = CNT_W'(in_free_slot);
              wsel_nxt = fs_word;
              if (CMP_W'(in_free_buffer) < CMP_W'(open_r) &&
                  CNT_W'(in_free_slot) < n_eff) begin
                bm_raddr  = word_addr(in_free_buffer, fs_word);
                bu_raddr  = in_free_buffer;
                state_nxt = bsa_pkg::S_FCHK;
              end else begin
                res_status_nxt = bsa_pkg::STAT_BAD_FREE;
              end
            end
            bsa_pkg::ACT_CLEAR: begin
              has_space_nxt = '0;
              open_nxt      = '0;
              total_nxt     = '0;
            end
            default: begin
            end
          endcase
        end
      end

      bsa_pkg::S_ACNT: begin
        cnt_nxt   = bu_rd;
        wsel_nxt  = word_of(bu_rd);
        bm_raddr  = word_addr(pick_r, word_of(bu_rd));
        state_nxt = bsa_pkg::S_ACHK;
      end

      bsa_pkg::S_ACHK: begin
        if (cnt_r < CNT_W'(SLOTS_MAX) && bm_rd[bit_idx]) begin
          commit_en   = 1'b1;
          commit_word = bm_rd;
          commit_bit  = bit_idx;
          commit_slot = SLOT_W'(cnt_r);
        end else begin
          scan_w_nxt   = '0;
          scan_vld_nxt = 1'b0;
          state_nxt    = bsa_pkg::S_SCAN;
        end
      end

      // one read issued per cycle, data checked in the following cycle
      bsa_pkg::S_SCAN: begin
        if (scan_vld_r && bm_rd != '0) begin
          word_nxt     = bm_rd;
          wsel_nxt     = scan_cw_r;
          scan_vld_nxt = 1'b0;
          state_nxt    = bsa_pkg::S_FIND;
        end else if (scan_vld_r && scan_cw_r == WIDX_W'(WPB - 1)) begin
          has_space_nxt[pick_r] = 1'b0;
          res_status_nxt        = bsa_pkg::STAT_FULL;
          scan_vld_nxt          = 1'b0;
          state_nxt             = bsa_pkg::S_RES;
        end else begin
          bm_raddr     = word_addr(pick_r, WIDX_W'(scan_w_r));
          scan_vld_nxt = (scan_w_r < SCW_W'(WPB));
          scan_cw_nxt  = WIDX_W'(scan_w_r);
          if (scan_w_r < SCW_W'(WPB)) begin
            scan_w_nxt = scan_w_r + SCW_W'(1);
          end
        end
      end

      bsa_pkg::S_FIND: begin
        commit_en = 1'b1;
      end

      bsa_pkg::S_OPEN: begin
        bm_we    = 1'b1;
        bm_waddr = word_addr(pick_r, WIDX_W'(scan_w_r));
        bm_wdata = init_word;
        if (scan_w_r == '0) begin
          bu_we                 = 1'b1;
          bu_wdata              = CNT_W'(1);
          has_space_nxt[pick_r] = (n_eff > CNT_W'(1));
          open_nxt              = open_r + OPEN_W'(1);
          total_nxt             = total_r + TOT_W'(1);
          res_gb_nxt            = pick_r;
          res_gs_nxt            = '0;
        end
        if (scan_w_r == SCW_W'(WPB - 1)) begin
          state_nxt = bsa_pkg::S_RES;
        end else begin
          scan_w_nxt = scan_w_r + SCW_W'(1);
        end
      end

      bsa_pkg::S_FCHK: begin
        state_nxt = bsa_pkg::S_RES;
        if (bm_rd[bit_idx]) begin
          res_status_nxt = bsa_pkg::STAT_BAD_FREE;
        end else begin
          bm_we                 = 1'b1;
          bm_wdata              = bm_rd | (WORD_BITS'(1) << bit_idx);
          bu_we                 = 1'b1;
          bu_wdata              = (bu_rd == '0) ? '0 : bu_rd - CNT_W'(1);
          has_space_nxt[pick_r] = 1'b1;
          total_nxt             = (total_r == '0) ? '0 : total_r - TOT_W'(1);
        end
      end

      bsa_pkg::S_RES: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_status_nxt     = res_status_r;
          out_got_buffer_nxt = res_gb_r;
          out_got_slot_nxt   = res_gs_r;
          out_in_use_nxt     = total_r;
          state_nxt          = bsa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bsa_pkg::S_IDLE;
      end
    endcase

    // allocation write-back, shared by the direct hit and the search
    if (commit_en) begin
      bm_we                 = 1'b1;
      bm_waddr              = word_addr(pick_r, wsel_r);
      bm_wdata              = commit_word & ~(WORD_BITS'(1) << commit_bit);
      bu_we                 = 1'b1;
      bu_wdata              = cnt_inc;
      has_space_nxt[pick_r] = (cnt_inc < n_eff);
      total_nxt             = total_r + TOT_W'(1);
      res_gb_nxt            = pick_r;
      res_gs_nxt            = commit_slot;
      state_nxt             = bsa_pkg::S_RES;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsa_pkg::S_IDLE;
      slots_r     <= CNT_W'(SLOTS_MAX);
      has_space_r <= '0;
      open_r      <= '0;
      total_r     <= '0;
      scan_w_r    <= '0;
      scan_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slots_r     <= slots_nxt;
      has_space_r <= has_space_nxt;
      open_r      <= open_nxt;
      total_r     <= total_nxt;
      scan_w_r    <= scan_w_nxt;
      scan_vld_r  <= scan_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pick_r           <= pick_nxt;
    cnt_r            <= cnt_nxt;
    wsel_r           <= wsel_nxt;
    scan_cw_r        <= scan_cw_nxt;
    word_r           <= word_nxt;
    res_status_r     <= res_status_nxt;
    res_gb_r         <= res_gb_nxt;
    res_gs_r         <= res_gs_nxt;
    out_status_r     <= out_status_nxt;
    out_got_buffer_r <= out_got_buffer_nxt;
    out_got_slot_r   <= out_got_slot_nxt;
    out_in_use_r     <= out_in_use_nxt;
  end

  `BSA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready,
                   state_r != bsa_pkg::S_IDLE, "accepted word did not start work")
  `BSA_ASSERT_HOLDS(a_space_only_open, clk, rst_n, 1'b1, (has_space_r >> open_r) == '0,
                    "space flag set on a buffer that is not open")
  `BSA_ASSERT_HOLDS(a_find_has_bit, clk, rst_n, state_r == bsa_pkg::S_FIND, word_r != '0,
                    "search hit on an empty bitmap word")
  `BSA_ASSERT_HOLDS(a_open_bound, clk, rst_n, 1'b1, open_r <= OPEN_W'(MAX_BUFFERS),
                    "open buffer count beyond the buffer pool")

endmodule

FILE: sv/bsa_ram.sv
module bsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

FILE: test/tb.sv
module tb;

  localparam int MAX_BUFS = 8;
  localparam int SLOTS = 512;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  buffer;
    logic [8:0]  slot;
    logic [12:0] in_use;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = bsa_pkg::ACT_ALLOC;
  logic [2:0]  in_free_buffer = '0;
  logic [8:0]  in_free_slot = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [2:0]  out_got_buffer;
  logic [8:0]  out_got_slot;
  logic [12:0] out_in_use;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [9:0]  cfg_slots_per_buffer = 10'd512;

  // allocator state as the testbench sees it
  logic [SLOTS-1:0] slot_map [MAX_BUFS];
  int               buf_count [MAX_BUFS];
  bit               buf_has_room [MAX_BUFS];
  int               bufs_open = 0;
  int               slots_taken = 0;
  logic [9:0]       slots_cfg = 10'd512;

  alloc_result_t pending_results [$];
  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int out_stall_pct = 0;

  always #1 clk = ~clk;

  bitmap_slot_allocator uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_action            (in_action),
    .in_free_buffer       (in_free_buffer),
    .in_free_slot         (in_free_slot),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_got_buffer       (out_got_buffer),
    .out_got_slot         (out_got_slot),
    .out_in_use           (out_in_use),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_slots_per_buffer (cfg_slots_per_buffer)
  );

  function automatic int usable_slots();
    if (slots_cfg == 10'd0) return 1;
    if (slots_cfg > SLOTS) return SLOTS;
    return int'(slots_cfg);
  endfunction

  function automatic int first_free(input int b);
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_map[b][s]) return s;
    end
    return SLOTS;
  endfunction

  task automatic predict_action(input logic [1:0] act, input logic [2:0] fb,
                                input logic [8:0] fs);
    alloc_result_t r;
    int n, pick, cnt, s;
    r = '0;
    n = usable_slots();
    pick = MAX_BUFS;
    if (act == bsa_pkg::ACT_ALLOC) begin
      for (int b = MAX_BUFS - 1; b >= 0; b--) begin
        if (b < bufs_open && buf_has_room[b]) pick = b;
      end
      if (pick == MAX_BUFS && bufs_open < MAX_BUFS) begin
        pick = bufs_open;
        slot_map[pick] = '0;
        for (int i = 0; i < n; i++) slot_map[pick][i] = 1'b1;
        buf_count[pick] = 0;
        buf_has_room[pick] = 1'b1;
        bufs_open++;
      end
      if (pick == MAX_BUFS) begin
        r.status = bsa_pkg::STAT_FULL;
      end else begin
        cnt = buf_count[pick];
        // prefer the slot at the buffer's count, else lowest free
        if (cnt < SLOTS && slot_map[pick][cnt]) s = cnt;
        else s = first_free(pick);
        if (s >= SLOTS) begin
          buf_has_room[pick] = 1'b0;
          r.status = bsa_pkg::STAT_FULL;
        end else begin
          slot_map[pick][s] = 1'b0;
          buf_count[pick] = cnt + 1;
          slots_taken++;
          if (buf_count[pick] >= n) buf_has_room[pick] = 1'b0;
          r.status = bsa_pkg::STAT_OK;
          r.buffer = pick[2:0];
          r.slot = s[8:0];
        end
      end
    end else if (act == bsa_pkg::ACT_FREE) begin
      if (int'(fb) >= bufs_open || int'(fs) >= n) begin
        r.status = bsa_pkg::STAT_BAD_FREE;
      end else if (slot_map[fb][fs]) begin
        r.status = bsa_pkg::STAT_BAD_FREE;
      end else begin
        slot_map[fb][fs] = 1'b1;
        buf_has_room[fb] = 1'b1;
        if (buf_count[fb] > 0) buf_count[fb]--;
        if (slots_taken > 0) slots_taken--;
      end
    end else if (act == bsa_pkg::ACT_CLEAR) begin
      for (int b = 0; b < MAX_BUFS; b++) begin
        buf_count[b] = 0;
        buf_has_room[b] = 1'b0;
      end
      bufs_open = 0;
      slots_taken = 0;
    end
    r.in_use = slots_taken[12:0];
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic send_word(input logic [1:0] act, input logic [2:0] fb, input logic [8:0] fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_free_buffer <= fb;
    in_free_slot <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_action(act, fb, fs);
  endtask

  task automatic drain_results();
    if (pending_results.size() != 0) begin
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_slots_cfg(input logic [9:0] value);
    cfg_valid <= 1'b1;
    cfg_slots_per_buffer <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    slots_cfg = value;
    cfg_valid <= 1'b0;
  endtask

  // random open buffer, random start, first taken slot below the usable count
  task automatic find_taken_slot(output bit found, output int b, output int s);
    int n, start;
    found = 1'b0;
    b = 0;
    s = 0;
    n = usable_slots();
    if (bufs_open > 0) begin
      b = $urandom_range(bufs_open - 1);
      start = $urandom_range(n - 1);
      for (int k = 0; k < n; k++) begin
        if (!found && !slot_map[b][(start + k) % n]) begin
          found = 1'b1;
          s = (start + k) % n;
        end
      end
    end
  endtask

  task automatic send_random_word(input int alloc_permille);
    int r, b, s;
    bit found;
    logic [2:0] jb;
    logic [8:0] js;
    r = $urandom_range(999);
    jb = 3'($urandom_range(7));
    js = 9'($urandom_range(511));
    if (r < alloc_permille) begin
      send_word(bsa_pkg::ACT_ALLOC, jb, js);
    end else if (r < 880) begin
      find_taken_slot(found, b, s);
      if (found) send_word(bsa_pkg::ACT_FREE, b[2:0], s[8:0]);
      else send_word(bsa_pkg::ACT_FREE, jb, js);
    end else if (r < 985) begin
      send_word(bsa_pkg::ACT_FREE, jb, js);
    end else if (r < 990) begin
      send_word(bsa_pkg::ACT_CLEAR, jb, js);
    end else begin
      send_word(ACT_UNUSED, jb, js);
    end
  endtask

  task automatic test_basic_actions();
    send_word(bsa_pkg::ACT_ALLOC, 3'd0, 9'd0);
    send_word(bsa_pkg::ACT_FREE, 3'd0, 9'd0);
    send_word(bsa_pkg::ACT_FREE, 3'd0, 9'd0);      // already free
    send_word(bsa_pkg::ACT_FREE, 3'd7, 9'd0);      // buffer never opened
    send_word(bsa_pkg::ACT_FREE, 3'd0, 9'd511);    // top slot, still free
    send_word(ACT_UNUSED, 3'd7, 9'd511);
    drain_results();
  endtask

  task automatic test_all_buffers_full();
    write_slots_cfg(10'd1);
    repeat (MAX_BUFS + 1) send_word(bsa_pkg::ACT_ALLOC, 3'd0, 9'd0);
    send_word(bsa_pkg::ACT_FREE, 3'd7, 9'd0);
    send_word(bsa_pkg::ACT_FREE, 3'd3, 9'd1);      // at or above slots per buffer
    send_word(bsa_pkg::ACT_ALLOC, 3'd0, 9'd0);
    drain_results();
  endtask

  // has_space left set on a buffer whose bitmap is exhausted
  task automatic test_stale_space_flag();
    write_slots_cfg(10'd2);
    send_word(bsa_pkg::ACT_CLEAR, 3'd0, 9'd0);
    send_word(bsa_pkg::ACT_ALLOC, 3'd0, 9'd0);
    drain_results();
    write_slots_cfg(10'd3);
    send_word(bsa_pkg::ACT_FREE, 3'd0, 9'd2);
    repeat (4) send_word(bsa_pkg::ACT_ALLOC, 3'd0, 9'd0);
    drain_results();
  endtask

  task automatic run_phase(input logic [9:0] spb, input int send_idle, input int recv_stall,
                           input int words, input int alloc_permille);
    write_slots_cfg(spb);
    send_idle_pct = send_idle;
    out_stall_pct <= recv_stall;
    repeat (words) begin
      send_random_word(alloc_permille);
      if ($urandom_range(149) == 0) drain_results();
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    run_phase(10'd4, 0, 0, 200, 600);
    run_phase(10'd1, 61, 0, 200, 600);
    run_phase(10'd0, 0, 61, 150, 550);
    run_phase(10'd7, 34, 34, 200, 650);
    run_phase(10'd512, 0, 0, 150, 600);
    run_phase(10'd1023, 61, 0, 100, 600);
    run_phase(10'd513, 0, 61, 100, 550);
    run_phase(10'd64, 34, 34, 200, 700);
    run_phase(10'd2, 0, 0, 200, 600);
    run_phase(10'($urandom_range(1, 16)), 34, 34, 200, 620);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result word: status %0d buffer %0d slot %0d in_use %0d",
                   out_status, out_got_buffer, out_got_slot, out_in_use);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_got_buffer !== want.buffer ||
            out_got_slot !== want.slot || out_in_use !== want.in_use) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.status, want.buffer, want.slot, want.in_use,
                     out_status, out_got_buffer, out_got_slot, out_in_use);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int b = 0; b < MAX_BUFS; b++) begin
      slot_map[b] = '0;
      buf_count[b] = 0;
      buf_has_room[b] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_actions();
    test_all_buffers_full();
    test_stale_space_flag();
    test_random_traffic();
    drain_results();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
